[rtl/core/rgb_to_hsv_pixel_defines.svh]
// assertion macros for the rgb_to_hsv_pixel checker
`ifndef RGB_TO_HSV_PIXEL_DEFINES_SVH
`define RGB_TO_HSV_PIXEL_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define RHP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define RHP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rhp_pkg.sv]
// types and constants shared by the rgb_to_hsv_pixel modules
package rhp_pkg;

    // widths of pixel channels, quotients, partial remainders and dividends
    localparam int PIX_W = 8;
    localparam int QUO_W = 8;
    localparam int REM_W = 16;
    localparam int ACC_W = 17;

    // scale factors and hue sector offsets, hue in units of two degrees
    localparam logic [PIX_W-1:0] SAT_SCALE    = 8'd255;
    localparam logic [PIX_W-1:0] HUE_SCALE    = 8'd30;
    localparam logic [PIX_W-1:0] HUE_RED_WRAP = 8'd180;
    localparam logic [PIX_W-1:0] HUE_GREEN    = 8'd60;
    localparam logic [PIX_W-1:0] HUE_BLUE     = 8'd120;
    localparam logic [PIX_W-1:0] HUE_RED      = 8'd0;

    // data handed from cell to cell: two restoring divisions side by side
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [REM_W-1:0] sat_rem;
        logic [PIX_W-1:0] sat_div;
        logic [QUO_W-1:0] sat_quo;
        logic [REM_W-1:0] hue_rem;
        logic [PIX_W-1:0] hue_div;
        logic [QUO_W-1:0] hue_quo;
    } rhp_data_t;

endpackage

[rtl/core/rhp_front.sv]
// front cell: max, min, spread and the two division operands
module rhp_front import rhp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    output logic             out_valid,
    input  logic             out_stall,
    output rhp_data_t        out_data
);

    logic             valid_reg;
    rhp_data_t        data_reg;
    rhp_data_t        data_next;
    logic             load;
    logic             red_max;
    logic             green_max;
    logic             gray;
    logic [PIX_W-1:0] max_ch;
    logic [PIX_W-1:0] min_ch;
    logic [PIX_W-1:0] spread;
    logic [PIX_W-1:0] hue_base;
    logic [PIX_W-1:0] hue_pos;
    logic [PIX_W-1:0] hue_neg;
    logic [ACC_W-1:0] sat_numer;
    logic [ACC_W-1:0] hue_numer;

    // stage takes a new transfer when empty or when its content moves on
    assign load      = !valid_reg || !out_stall;
    assign in_stall  = !load;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // max with red winning ties over green, green over blue
    always_comb
    begin
        red_max   = (red >= green) && (red >= blue);
        green_max = !red_max && (green >= blue);
        if (red_max)
        begin
            max_ch = red;
        end
        else if (green_max)
        begin
            max_ch = green;
        end
        else
        begin
            max_ch = blue;
        end
        min_ch = (red <= green) ? red : green;
        if (blue < min_ch)
        begin
            min_ch = blue;
        end
        spread = max_ch - min_ch;
        gray   = (spread == '0);
    end

    // hue sector: base offset plus or minus the scaled channel difference
    always_comb
    begin
        hue_pos = '0;
        hue_neg = '0;
        if (red_max)
        begin
            if (green >= blue)
            begin
                hue_base = HUE_RED;
                hue_pos  = green - blue;
            end
            else
            begin
                hue_base = HUE_RED_WRAP;
                hue_neg  = blue - green;
            end
        end
        else if (green_max)
        begin
            hue_base = HUE_GREEN;
            if (blue >= red)
            begin
                hue_pos = blue - red;
            end
            else
            begin
                hue_neg = red - blue;
            end
        end
        else
        begin
            hue_base = HUE_BLUE;
            if (red >= green)
            begin
                hue_pos = red - green;
            end
            else
            begin
                hue_neg = green - red;
            end
        end
        sat_numer = ACC_W'(SAT_SCALE) * ACC_W'(spread);
        hue_numer = ACC_W'(hue_base) * ACC_W'(spread)
                  + ACC_W'(HUE_SCALE) * ACC_W'(hue_pos)
                  - ACC_W'(HUE_SCALE) * ACC_W'(hue_neg);
    end

    // gray pixels divide zero by one so both quotients come out zero
    always_comb
    begin
        data_next.value   = max_ch;
        data_next.sat_quo = '0;
        data_next.hue_quo = '0;
        if (gray)
        begin
            data_next.sat_rem = '0;
            data_next.sat_div = PIX_W'(1);
            data_next.hue_rem = '0;
            data_next.hue_div = PIX_W'(1);
        end
        else
        begin
            data_next.sat_rem = sat_numer[REM_W-1:0];
            data_next.sat_div = max_ch;
            data_next.hue_rem = hue_numer[REM_W-1:0];
            data_next.hue_div = spread;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/core/rhp_div_cell.sv]
// divider cell: settles one quotient bit of saturation and of hue
module rhp_div_cell import rhp_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  rhp_data_t in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output rhp_data_t out_data
);

    logic             valid_reg;
    rhp_data_t        data_reg;
    rhp_data_t        data_next;
    logic             load;
    logic             sat_fit;
    logic             hue_fit;
    logic [REM_W-1:0] sat_shift_div;
    logic [REM_W-1:0] hue_shift_div;

    // stage takes a new transfer when empty or when its content moves on
    assign load      = !valid_reg || !out_stall;
    assign in_stall  = !load;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // restoring step: subtract the divisor at this bit weight if it fits
    always_comb
    begin
        sat_shift_div = REM_W'(in_data.sat_div) << BIT;
        hue_shift_div = REM_W'(in_data.hue_div) << BIT;
        sat_fit       = (in_data.sat_rem >> BIT) >= REM_W'(in_data.sat_div);
        hue_fit       = (in_data.hue_rem >> BIT) >= REM_W'(in_data.hue_div);
        data_next     = in_data;
        if (sat_fit)
        begin
            data_next.sat_rem      = in_data.sat_rem - sat_shift_div;
            data_next.sat_quo[BIT] = 1'b1;
        end
        if (hue_fit)
        begin
            data_next.hue_rem      = in_data.hue_rem - hue_shift_div;
            data_next.hue_quo[BIT] = 1'b1;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/core/rgb_to_hsv_pixel.sv]
// top level of the rgb to hsv pixel converter
//
// Converts one 8-bit RGB pixel per transfer into value, saturation and
// hue (hue in units of two degrees, 0 to 179).
// Input channel: in_valid / in_stall with red, green, blue.
// Output channel: out_valid / out_stall with value, saturation, hue.
// A transfer happens on a rising clk edge with valid high and stall low.
// Nine register stages: one front cell (max, min, spread, dividends) and
// a chain of 8 divider cells, each settling one quotient bit of both
// divisions. The front cell loads at the input transfer edge, and the
// result moves on through each divider cell in turn before it is shown
// on the output channel.
// Throughput is one pixel per clock while out_stall stays low.
// When the receiver stalls, the last cell holds its result and the cells
// behind it keep filling; in_stall rises only once every cell is full.
// Reset (rst_n low, asynchronous) empties every cell; no result is shown
// until a new pixel has passed through the chain.
module rgb_to_hsv_pixel import rhp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [PIX_W-1:0] red,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] blue,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [PIX_W-1:0] value,
    output logic [PIX_W-1:0] saturation,
    output logic [PIX_W-1:0] hue
);

    logic      stage_valid [0:QUO_W];
    logic      stage_stall [0:QUO_W];
    rhp_data_t stage_data  [0:QUO_W];

    // front cell
    rhp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (stage_valid[0]),
        .out_stall (stage_stall[0]),
        .out_data  (stage_data[0])
    );

    // divider cells, most significant quotient bit first
    for (genvar i = 0; i < QUO_W; i++)
    begin : g_cell
        rhp_div_cell #(
            .BIT (QUO_W - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_stall  (stage_stall[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_stall (stage_stall[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    // last cell drives the output channel
    assign stage_stall[QUO_W] = out_stall;
    assign out_valid          = stage_valid[QUO_W];
    assign value              = stage_data[QUO_W].value;
    assign saturation         = stage_data[QUO_W].sat_quo;
    assign hue                = stage_data[QUO_W].hue_quo;

endmodule

[rtl/core/rhp_checker.sv]
// port-level checks for rgb_to_hsv_pixel and the bind that attaches them
`include "rgb_to_hsv_pixel_defines.svh"

module rhp_checker import rhp_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input logic [PIX_W-1:0] value,
    input logic [PIX_W-1:0] saturation,
    input logic [PIX_W-1:0] hue
);

    // hue never leaves the circle of 180 two-degree steps
    `RHP_ASSERT_SAME(a_hue_range, out_valid, hue <= 8'd179, "hue above 179")

    // black pixel gives zero saturation and hue
    `RHP_ASSERT_SAME(a_black_zero, out_valid && value == '0,
                     saturation == '0 && hue == '0, "black pixel with color")

    // colored pixel always has nonzero saturation, so zero saturation means gray
    `RHP_ASSERT_SAME(a_gray_hue, out_valid && value != '0 && saturation == '0,
                     hue == '0, "gray pixel with nonzero hue")

    // a stalled result holds until its transfer
    `RHP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                     out_valid && $stable(value) && $stable(saturation) && $stable(hue),
                     "stalled result changed")

endmodule

bind rgb_to_hsv_pixel rhp_checker u_rhp_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 100ps
// testbench for rgb_to_hsv_pixel: corner and random pixels checked against a local hsv predictor
module tb_top;
    import rhp_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_PIXELS = 550;
    localparam int CORNER_COUNT  = 24;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [PIX_W-1:0] saturation;
        logic [PIX_W-1:0] hue;
    } hsv_t;

    // expected hsv results in transfer order, with the prediction that fills them
    class hsv_tracker;
        hsv_t expected_hsv[$];
        int   mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        // integer hexcone conversion, hue in units of two degrees
        function hsv_t predict_hsv(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                   logic [PIX_W-1:0] b);
            logic [PIX_W-1:0] vmax;
            logic [PIX_W-1:0] vmin;
            logic [PIX_W-1:0] spread;
            int unsigned      sat;
            int unsigned      hue_half;
            hsv_t             res;
            vmax     = (r >= g) ? ((r >= b) ? r : b) : ((g >= b) ? g : b);
            vmin     = (r <= g) ? ((r <= b) ? r : b) : ((g <= b) ? g : b);
            spread   = vmax - vmin;
            sat      = 0;
            hue_half = 0;
            if (vmax != 0 && spread != 0)
            begin
                sat = (255 * spread) / vmax;
                // red wins ties over green, green over blue
                if (vmax == r)
                begin
                    if (g >= b)
                        hue_half = (30 * (g - b)) / spread;
                    else
                        hue_half = (180 * spread - 30 * (b - g)) / spread;
                end
                else if (vmax == g)
                    hue_half = (60 * spread + 30 * b - 30 * r) / spread;
                else
                    hue_half = (120 * spread + 30 * r - 30 * g) / spread;
            end
            res.value      = vmax;
            res.saturation = sat[PIX_W-1:0];
            res.hue        = hue_half[PIX_W-1:0];
            return res;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                                 logic [PIX_W-1:0] b);
            expected_hsv.push_back(predict_hsv(r, g, b));
        endfunction

        function void compare_field(string field, logic [PIX_W-1:0] want,
                                    logic [PIX_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, field, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(logic [PIX_W-1:0] v, logic [PIX_W-1:0] s,
                                   logic [PIX_W-1:0] h);
            hsv_t want;
            if (expected_hsv.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d",
                         $time, v, s, h);
                mismatch_count++;
                return;
            end
            want = expected_hsv.pop_front();
            compare_field("value", want.value, v);
            compare_field("saturation", want.saturation, s);
            compare_field("hue", want.hue, h);
        endfunction

        function int pending();
            return expected_hsv.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             out_valid;
    logic             out_stall;
    logic [PIX_W-1:0] value;
    logic [PIX_W-1:0] saturation;
    logic [PIX_W-1:0] hue;

    hsv_tracker tracker = new();
    int         result_count;
    int         idle_cycles;

    // corner pixels as red, green, blue bytes
    logic [23:0] corner_pixels [CORNER_COUNT] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF0100, 24'h010000,
        24'hFFFEFE, 24'h000100, 24'h000001, 24'h0A141E, 24'h1E140A, 24'hFF0080,
        24'h80FF00, 24'h0080FF, 24'h010100, 24'h000101, 24'h010001, 24'hFEFFFF
    };

    rgb_to_hsv_pixel i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .saturation (saturation),
        .hue        (hue)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // sender gap, with calm stretches where it never idles
    function int sender_gap(int idx);
        if ((idx / 40) % 3 == 0)
            return 0;
        return $urandom_range(0, 4);
    endfunction

    // one pixel transfer; entered and left at a falling edge
    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input int gap);
        bit accepted;
        accepted = 1'b0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        red      = r;
        green    = g;
        blue     = b;
        in_valid = 1'b1;
        while (!accepted)
        begin
            @(posedge clk);
            if (!in_stall)
            begin
                tracker.note_pixel(r, g, b);
                accepted = 1'b1;
            end
            @(negedge clk);
        end
    endtask

    // random pixel: mostly free, some near-gray, some with tied channels
    task automatic make_pixel(output logic [PIX_W-1:0] r, output logic [PIX_W-1:0] g,
                              output logic [PIX_W-1:0] b);
        int          kind;
        logic [7:0]  base;
        logic [7:0]  other;
        kind  = $urandom_range(0, 9);
        base  = 8'($urandom_range(0, 255));
        other = 8'($urandom_range(0, 255));
        if (kind <= 5)
        begin
            r = 8'($urandom_range(0, 255));
            g = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
        end
        else if (kind <= 7)
        begin
            r = base ^ 8'($urandom_range(0, 3));
            g = base ^ 8'($urandom_range(0, 3));
            b = base ^ 8'($urandom_range(0, 3));
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    r = base; g = base; b = other;
                end
                1:
                begin
                    r = other; g = base; b = base;
                end
                default:
                begin
                    r = base; g = other; b = base;
                end
            endcase
        end
    endtask

    // stimulus and end of run
    initial
    begin
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        in_valid = 1'b0;
        red      = '0;
        green    = '0;
        blue     = '0;
        rst_n    = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // corner pixels
        for (int i = 0; i < CORNER_COUNT; i++)
        begin
            send_pixel(corner_pixels[i][23:16], corner_pixels[i][15:8],
                       corner_pixels[i][7:0], $urandom_range(0, 2));
        end

        // random pixels, with one full drain halfway
        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            if (i == RANDOM_PIXELS / 2)
            begin
                in_valid = 1'b0;
                while (tracker.pending() != 0)
                    @(negedge clk);
            end
            make_pixel(r, g, b);
            send_pixel(r, g, b, sender_gap(i));
        end
        in_valid = 1'b0;

        // drain, then settle
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // result side: sample at rising edge, stall drawn per result
    initial
    begin
        int stall_left;
        stall_left   = 0;
        result_count = 0;
        out_stall    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                tracker.check_result(value, saturation, hue);
                result_count++;
                stall_left = ((result_count / 40) % 3 == 1) ? 0 : $urandom_range(0, 4);
            end
            @(negedge clk);
            out_stall = (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/rhp_pkg.sv
rtl/core/rhp_front.sv
rtl/core/rhp_div_cell.sv
rtl/core/rgb_to_hsv_pixel.sv
rtl/core/rhp_checker.sv
tb/tb_top.sv
